### src/dsc_pkg.sv
// Shared constants, command/status types and result codes for the
// divisor-sum classifier. No dependencies.
package dsc_pkg;

  localparam int VALUE_BITS  = 16;              // bits of the number that are used
  localparam int NUMBER_W    = 16;              // input field width
  localparam int CAT_W       = 2;
  localparam int ABUND_W     = 18;
  localparam int DEFIC_W     = 16;
  localparam int SUM_W       = VALUE_BITS + 3;  // proper divisor sum < 8n
  localparam int CNT_W       = $clog2(VALUE_BITS);
  localparam int IN_TDATA_W  = 16;
  localparam int RES_W       = CAT_W + ABUND_W + DEFIC_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int PAD_W       = OUT_TDATA_W - RES_W;

  localparam logic [CAT_W-1:0] CAT_DEFICIENT = 2'd0;
  localparam logic [CAT_W-1:0] CAT_PERFECT   = 2'd1;
  localparam logic [CAT_W-1:0] CAT_ABUNDANT  = 2'd2;

  typedef struct packed {
    logic load;    // latch a new number, restart candidate and sum
    logic step;    // one restoring-division bit for the current candidate
    logic result;  // classify and load the output register
  } dsc_cmd_t;

  typedef struct packed {
    logic small_in;   // incoming number is 0 or 1: no candidates
    logic div_last;   // this step finishes the current remainder
    logic cand_done;  // next candidate would reach the number
    logic add_busy;   // a divisor hit still waits to be summed
  } dsc_status_t;

endpackage

### src/dsc_datapath.sv
// Datapath: held number, candidate counter, bit-serial remainder unit,
// divisor sum accumulator and output register. Uses dsc_pkg.
module dsc_datapath
  import dsc_pkg::*;
(
  input  logic                clk,
  input  logic [NUMBER_W-1:0] number,
  input  dsc_cmd_t            cmd,
  output dsc_status_t         status,
  output logic [CAT_W-1:0]    category,
  output logic [ABUND_W-1:0]  abundance,
  output logic [DEFIC_W-1:0]  deficiency
);

  logic [VALUE_BITS-1:0] n_in;
  logic [VALUE_BITS-1:0] held_number;
  logic [VALUE_BITS-1:0] cand;
  logic [VALUE_BITS-1:0] shreg;
  logic [VALUE_BITS-1:0] rem;
  logic [CNT_W-1:0]      cnt;
  logic [SUM_W-1:0]      sum;
  logic                  pend;
  logic [VALUE_BITS-1:0] pend_val;

  logic [VALUE_BITS:0]   partial;
  logic [VALUE_BITS:0]   diff;
  logic [VALUE_BITS:0]   cand_inc;
  logic [VALUE_BITS-1:0] rem_new;
  logic                  fits;
  logic [SUM_W-1:0]      n_ext;

  assign n_in     = VALUE_BITS'(number);
  assign partial  = {rem, shreg[VALUE_BITS-1]};
  assign diff     = partial - {1'b0, cand};
  assign fits     = partial >= {1'b0, cand};
  assign rem_new  = fits ? diff[VALUE_BITS-1:0] : partial[VALUE_BITS-1:0];
  assign cand_inc = {1'b0, cand} + (VALUE_BITS+1)'(1);
  assign n_ext    = SUM_W'(held_number);

  assign status.small_in  = n_in <= VALUE_BITS'(1);
  assign status.div_last  = cnt == CNT_W'(VALUE_BITS - 1);
  assign status.cand_done = cand_inc >= {1'b0, held_number};
  assign status.add_busy  = pend;

  always_ff @(posedge clk) begin
    if (pend && !cmd.load) begin
      sum <= sum + SUM_W'(pend_val);
    end
    if (cmd.load) begin
      held_number <= n_in;
      cand        <= VALUE_BITS'(1);
      shreg       <= n_in;
      rem         <= '0;
      cnt         <= '0;
      sum         <= '0;
      pend        <= 1'b0;
    end else if (cmd.step) begin
      if (status.div_last) begin
        // remainder done: flag a hit, move on to the next candidate
        pend     <= rem_new == '0;
        pend_val <= cand;
        cand     <= cand_inc[VALUE_BITS-1:0];
        shreg    <= held_number;
        rem      <= '0;
        cnt      <= '0;
      end else begin
        pend  <= 1'b0;
        shreg <= {shreg[VALUE_BITS-2:0], 1'b0};
        rem   <= rem_new;
        cnt   <= cnt + CNT_W'(1);
      end
    end else begin
      pend <= 1'b0;
    end
    if (cmd.result) begin
      if (sum < n_ext) begin
        category   <= CAT_DEFICIENT;
        abundance  <= '0;
        deficiency <= DEFIC_W'(n_ext - sum);
      end else if (sum == n_ext) begin
        category   <= CAT_PERFECT;
        abundance  <= '0;
        deficiency <= '0;
      end else begin
        category   <= CAT_ABUNDANT;
        abundance  <= ABUND_W'(sum - n_ext);
        deficiency <= '0;
      end
    end
  end

endmodule

### src/dsc_ctrl.sv
// Controller state machine: sequences load, division steps, final sum and
// the output register handshake. Uses dsc_pkg.
module dsc_ctrl
  import dsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  dsc_status_t status,
  output dsc_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready = state == ST_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.small_in ? ST_FLUSH : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.div_last && status.cand_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // let the last divisor hit land in the sum
        if (!status.add_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.result = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/divisor_sum_classifier.sv
// Top level of the divisor-sum classifier: joins controller and datapath
// and packs the stream words. Uses dsc_pkg, dsc_ctrl, dsc_datapath.
//
// Usage:
//   Slave channel (s_*) takes one word per number n in s_tdata[15:0]; only
//   the low VALUE_BITS bits are used. Master channel (m_*) returns one word
//   per number: category (0 deficient, 1 perfect, 2 abundant), the
//   abundance s-n and the deficiency n-s, where s is the proper divisor sum.
//   Every candidate i in 1..n-1 is tested with a bit-serial restoring
//   remainder unit that resolves one bit per cycle. One number is worked
//   on at a time; s_tready is high only while the unit is idle, so a new
//   number is taken only once the previous one has been computed.
//   The result sits in an output register, so a new number is accepted and
//   computed while the previous word waits on m_tready; only the final
//   load of the output register waits for the register to free up.
//   Reset (rst, synchronous, active high) drops any number in flight and
//   any pending result word.
module divisor_sum_classifier
  import dsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] number
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [1:0] category, [19:2] abundance,
                                            // [35:20] deficiency, rest zero
);

  dsc_cmd_t            cmd;
  dsc_status_t         status;
  logic [CAT_W-1:0]    category;
  logic [ABUND_W-1:0]  abundance;
  logic [DEFIC_W-1:0]  deficiency;

  dsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dsc_datapath u_datapath (
    .clk        (clk),
    .number     (s_tdata[NUMBER_W-1:0]),
    .cmd        (cmd),
    .status     (status),
    .category   (category),
    .abundance  (abundance),
    .deficiency (deficiency)
  );

  // pack result word, first field in the low bits, zero fill to bytes
  assign m_tdata = {{PAD_W{1'b0}}, deficiency, abundance, category};

endmodule

### src/dsc_checker.sv
// Port-level checker for the divisor-sum classifier, bound to the top
// level. Uses dsc_pkg.
module dsc_checker
  import dsc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [CAT_W-1:0]   cat;
  logic [ABUND_W-1:0] abund;
  logic [DEFIC_W-1:0] defic;

  assign cat   = m_tdata[CAT_W-1:0];
  assign abund = m_tdata[CAT_W+ABUND_W-1:CAT_W];
  assign defic = m_tdata[RES_W-1:CAT_W+ABUND_W];

  // hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // a number keeps the unit busy: no accept right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // result fields agree with the category
  a_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((cat == CAT_DEFICIENT && abund == '0 && defic != '0) ||
                  (cat == CAT_PERFECT && abund == '0 && defic == '0) ||
                  (cat == CAT_ABUNDANT && abund != '0 && defic == '0)))
    else $error("inconsistent result fields");

  // no result word right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word after reset");

endmodule

bind divisor_sum_classifier dsc_checker u_dsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
